// ----- rtl/core/prdt_pkg.sv -----
// ----------------------------------------------------------------------------
// prdt_pkg
// Types and codes shared by the prescaled reload down timer.
// ----------------------------------------------------------------------------
package prdt_pkg;

  localparam int unsigned DATA_W = 16;
  localparam int unsigned PSC_W  = 16;

  // action codes
  localparam logic [1:0] ACT_TICK  = 2'd0;
  localparam logic [1:0] ACT_READ  = 2'd1;
  localparam logic [1:0] ACT_WRITE = 2'd2;

  // register selects
  localparam logic [2:0] REG_CTRL  = 3'd0;
  localparam logic [2:0] REG_PSC   = 3'd1;
  localparam logic [2:0] REG_ARR   = 3'd2;
  localparam logic [2:0] REG_CNT   = 3'd3;
  localparam logic [2:0] REG_EGR   = 3'd4;
  localparam logic [2:0] REG_SR    = 3'd5;
  localparam logic [2:0] REG_IER   = 3'd6;

  // control register bit positions
  localparam int unsigned CTRL_EN_BIT  = 0;
  localparam int unsigned CTRL_OPM_BIT = 3;
  localparam int unsigned CTRL_DIR_BIT = 4;

  typedef struct packed {
    logic [1:0]        action;
    logic [2:0]        reg_select;
    logic [DATA_W-1:0] write_data;
  } in_item_t;

  typedef struct packed {
    logic [DATA_W-1:0] read_data;
    logic              update_pending;
    logic              irq;
    logic              running;
  } out_item_t;

endpackage

// ----- rtl/core/prescaled_reload_down_timer.sv -----
// ----------------------------------------------------------------------------
// prescaled_reload_down_timer
// Prescaled reload timer driven by a stream of tick / read / write words.
// ----------------------------------------------------------------------------
//  channel | signals                         | word
//  --------+---------------------------------+-----------------------------
//  in      | in_valid, in_ready, in_data     | action, reg_select, data
//  out     | out_valid, out_ready, out_data  | read_data, flags, running
//
//  One word per clock while the output is not stalled; each word passes the
//  input register, then the register update and result register in one pass.
//  Synchronous reset clears the timer registers, reload goes to all ones.
//  A stalled output holds its word; the input register still takes a new
//  word whenever its content moves on in the same cycle.
// ----------------------------------------------------------------------------
module prescaled_reload_down_timer import prdt_pkg::*; #(
  parameter int unsigned COUNTER_WIDTH = 16
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  logic      s1_valid;
  in_item_t  s1_item;
  out_item_t exec_result;
  logic      advance;

  assign advance  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_item <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= exec_result;
    end
  end

  prdt_core #(
    .COUNTER_WIDTH (COUNTER_WIDTH)
  ) u_core (
    .clk    (clk),
    .rst    (rst),
    .commit (advance),
    .item   (s1_item),
    .result (exec_result)
  );

endmodule

// ----- rtl/core/prdt_core.sv -----
// ----------------------------------------------------------------------------
// prdt_core
// Timer register file and the update for one bus word, taken on commit.
// ----------------------------------------------------------------------------
module prdt_core import prdt_pkg::*; #(
  parameter int unsigned COUNTER_WIDTH = 16
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      commit,
  input  in_item_t  item,
  output out_item_t result
);

  logic                     enable_bit,        enable_bit_next;
  logic                     one_pulse_bit,     one_pulse_bit_next;
  logic                     count_down_bit,    count_down_bit_next;
  logic [PSC_W-1:0]         prescale_value,    prescale_value_next;
  logic [PSC_W-1:0]         prescale_count,    prescale_count_next;
  logic [COUNTER_WIDTH-1:0] reload_value,      reload_value_next;
  logic [COUNTER_WIDTH-1:0] count_value,       count_value_next;
  logic                     update_flag,       update_flag_next;
  logic                     update_irq_enable, update_irq_enable_next;
  logic [DATA_W-1:0]        rd;
  logic                     wrapped;

  always_ff @(posedge clk) begin
    if (rst) begin
      enable_bit        <= 1'b0;
      one_pulse_bit     <= 1'b0;
      count_down_bit    <= 1'b0;
      prescale_value    <= '0;
      prescale_count    <= '0;
      reload_value      <= '1;
      count_value       <= '0;
      update_flag       <= 1'b0;
      update_irq_enable <= 1'b0;
    end else if (commit) begin
      enable_bit        <= enable_bit_next;
      one_pulse_bit     <= one_pulse_bit_next;
      count_down_bit    <= count_down_bit_next;
      prescale_value    <= prescale_value_next;
      prescale_count    <= prescale_count_next;
      reload_value      <= reload_value_next;
      count_value       <= count_value_next;
      update_flag       <= update_flag_next;
      update_irq_enable <= update_irq_enable_next;
    end
  end

  always_comb begin
    enable_bit_next        = enable_bit;
    one_pulse_bit_next     = one_pulse_bit;
    count_down_bit_next    = count_down_bit;
    prescale_value_next    = prescale_value;
    prescale_count_next    = prescale_count;
    reload_value_next      = reload_value;
    count_value_next       = count_value;
    update_flag_next       = update_flag;
    update_irq_enable_next = update_irq_enable;
    rd                     = '0;
    wrapped                = 1'b0;

    case (item.action)
      ACT_TICK: begin
        if (enable_bit) begin
          if (prescale_count >= prescale_value) begin
            prescale_count_next = '0;
            if (count_down_bit) begin
              if (count_value == '0) begin
                count_value_next = reload_value;
                wrapped          = 1'b1;
              end else begin
                count_value_next = count_value - 1'b1;
              end
            end else begin
              if (count_value >= reload_value) begin
                count_value_next = '0;
                wrapped          = 1'b1;
              end else begin
                count_value_next = count_value + 1'b1;
              end
            end
          end else begin
            prescale_count_next = prescale_count + 1'b1;
          end
        end
        if (wrapped) begin
          update_flag_next = 1'b1;
          if (one_pulse_bit) begin
            enable_bit_next = 1'b0;
          end
        end
      end
      ACT_READ: begin
        case (item.reg_select)
          REG_CTRL: begin
            rd[CTRL_EN_BIT]  = enable_bit;
            rd[CTRL_OPM_BIT] = one_pulse_bit;
            rd[CTRL_DIR_BIT] = count_down_bit;
          end
          REG_PSC: rd = prescale_value;
          REG_ARR: rd = DATA_W'(reload_value);
          REG_CNT: rd = DATA_W'(count_value);
          REG_SR:  rd = DATA_W'(update_flag);
          REG_IER: rd = DATA_W'(update_irq_enable);
          default: rd = '0;
        endcase
      end
      ACT_WRITE: begin
        case (item.reg_select)
          REG_CTRL: begin
            enable_bit_next     = item.write_data[CTRL_EN_BIT];
            one_pulse_bit_next  = item.write_data[CTRL_OPM_BIT];
            count_down_bit_next = item.write_data[CTRL_DIR_BIT];
          end
          REG_PSC: prescale_value_next = item.write_data;
          REG_ARR: reload_value_next   = COUNTER_WIDTH'(item.write_data);
          REG_CNT: count_value_next    = COUNTER_WIDTH'(item.write_data);
          REG_EGR: begin
            if (item.write_data[0]) begin
              count_value_next    = count_down_bit ? reload_value : '0;
              prescale_count_next = '0;
              update_flag_next    = 1'b1;
            end
          end
          // writing 0 clears the flag, 1 leaves it
          REG_SR:  update_flag_next       = update_flag & item.write_data[0];
          REG_IER: update_irq_enable_next = item.write_data[0];
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  assign result.read_data      = rd;
  assign result.update_pending = update_flag_next;
  assign result.irq            = update_flag_next & update_irq_enable_next;
  assign result.running        = enable_bit_next;

endmodule

// ----- tb/prescaled_reload_down_timer_tb.sv -----
// ----------------------------------------------------------------------------
// prescaled_reload_down_timer_tb
// Self-checking bench for the prescaled reload timer. A directed table covers
// the reset values, field extremes and the timer's corner cases. Random tick,
// read and write words follow under three idling patterns. Every result word
// is checked against its table value if any, else a cycle-free timer model.
// ----------------------------------------------------------------------------
module prescaled_reload_down_timer_tb import prdt_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CNT_W       = 16;
  localparam logic [1:0]  ACT_NONE    = 2'd3;  // unused action
  localparam logic [2:0]  REG_NONE    = 3'd7;  // unused select
  localparam int unsigned HOLD_CYCLES = 100;
  localparam int unsigned QUIET_LIMIT = 2000;
  localparam int unsigned DRAIN_WAIT  = 8;
  localparam int unsigned RAND_PER_PHASE = 135;

  typedef struct {
    in_item_t  word;
    bit        typed;
    out_item_t resp;
  } dir_row_t;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  // word on offer carries its hand-written result, if any
  bit        word_typed = 1'b0;
  out_item_t word_resp  = '0;

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned hold_asked = 0;
  int unsigned hold_done  = 0;
  int unsigned hold_left  = 0;

  int unsigned mismatches = 0;
  int unsigned words_in   = 0;
  int unsigned words_out  = 0;
  int unsigned irq_words  = 0;
  int unsigned wraps_seen = 0;
  int unsigned quiet      = 0;

  out_item_t timer_words_due[$];
  dir_row_t  dir_rows[$];

  // timer state as the bench sees it
  logic             t_en, t_opm, t_down, t_uif, t_uie;
  logic [15:0]      t_psc, t_psc_cnt;
  logic [CNT_W-1:0] t_arr, t_cnt;

  always #4 clk = ~clk;

  prescaled_reload_down_timer dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  function automatic void reset_timer();
    t_en = 1'b0; t_opm = 1'b0; t_down = 1'b0;
    t_psc = '0; t_psc_cnt = '0;
    t_arr = '1; t_cnt = '0;
    t_uif = 1'b0; t_uie = 1'b0;
  endfunction

  function automatic void count_step();
    logic wrapped;
    wrapped = 1'b0;
    if (t_down) begin
      if (t_cnt == '0) begin
        t_cnt = t_arr; wrapped = 1'b1;
      end else begin
        t_cnt = t_cnt - 1'b1;
      end
    end else begin
      if (t_cnt >= t_arr) begin
        t_cnt = '0; wrapped = 1'b1;
      end else begin
        t_cnt = t_cnt + 1'b1;
      end
    end
    if (wrapped) begin
      wraps_seen++;
      t_uif = 1'b1;
      if (t_opm) t_en = 1'b0;
    end
  endfunction

  // Applies one word to the bench's timer and returns the result word due.
  function automatic out_item_t advance_timer(input in_item_t w);
    out_item_t r;
    r = '0;
    case (w.action)
      ACT_TICK: begin
        if (t_en) begin
          if (t_psc_cnt >= t_psc) begin
            t_psc_cnt = '0;
            count_step();
          end else begin
            t_psc_cnt = t_psc_cnt + 1'b1;
          end
        end
      end
      ACT_READ: begin
        case (w.reg_select)
          REG_CTRL: begin
            r.read_data[CTRL_EN_BIT]  = t_en;
            r.read_data[CTRL_OPM_BIT] = t_opm;
            r.read_data[CTRL_DIR_BIT] = t_down;
          end
          REG_PSC: r.read_data = t_psc;
          REG_ARR: r.read_data = t_arr;
          REG_CNT: r.read_data = t_cnt;
          REG_SR:  r.read_data[0] = t_uif;
          REG_IER: r.read_data[0] = t_uie;
          default: ;
        endcase
      end
      ACT_WRITE: begin
        case (w.reg_select)
          REG_CTRL: begin
            t_en   = w.write_data[CTRL_EN_BIT];
            t_opm  = w.write_data[CTRL_OPM_BIT];
            t_down = w.write_data[CTRL_DIR_BIT];
          end
          REG_PSC: t_psc = w.write_data;
          REG_ARR: t_arr = w.write_data[CNT_W-1:0];
          REG_CNT: t_cnt = w.write_data[CNT_W-1:0];
          REG_EGR: begin
            if (w.write_data[0]) begin
              t_cnt = t_down ? t_arr : '0;
              t_psc_cnt = '0;
              t_uif = 1'b1;
            end
          end
          REG_SR:  t_uif = t_uif & w.write_data[0];
          REG_IER: t_uie = w.write_data[0];
          default: ;
        endcase
      end
      default: ;
    endcase
    r.update_pending = t_uif;
    r.irq            = t_uif & t_uie;
    r.running        = t_en;
    return r;
  endfunction

  function automatic void add_row(input logic [1:0] a, input logic [2:0] s,
                                  input logic [15:0] d, input bit typed,
                                  input out_item_t resp);
    dir_row_t row;
    row.word.action     = a;
    row.word.reg_select = s;
    row.word.write_data = d;
    row.typed = typed;
    row.resp  = resp;
    dir_rows.push_back(row);
  endfunction

  // Mostly ticks and small timer settings so the counter wraps often; a tenth
  // of the words are pure noise over every field.
  function automatic in_item_t rand_timer_word();
    in_item_t    w;
    int unsigned pick;
    pick = $urandom_range(99);
    w.action     = ACT_TICK;
    w.reg_select = 3'($urandom_range(7));
    w.write_data = 16'($urandom);
    if (pick < 10) begin
      w.action = 2'($urandom_range(3));
    end else if (pick < 55) begin
      w.action = ACT_TICK;
    end else if (pick < 70) begin
      w.action = ACT_READ;
    end else begin
      w.action     = ACT_WRITE;
      w.reg_select = 3'($urandom_range(6));
      case (w.reg_select)
        REG_CTRL: w.write_data[CTRL_EN_BIT] = ($urandom_range(9) < 8);
        REG_PSC, REG_ARR, REG_CNT: begin
          if ($urandom_range(9) < 8) w.write_data = 16'($urandom_range(12));
        end
        default: ;
      endcase
    end
    return w;
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance
  // with valid still high.
  task automatic offer_word(input in_item_t w, input bit typed, input out_item_t resp);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid   = 1'b1;
    in_data    = w;
    word_typed = typed;
    word_resp  = resp;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic offer_random(input int unsigned n);
    repeat (n) offer_word(rand_timer_word(), 1'b0, '0);
  endtask

  task automatic wait_drained();
    in_valid = 1'b0;
    while (timer_words_due.size() != 0) @(negedge clk);
  endtask

  // receiver: random stalls plus a long hold-off whenever one is asked for
  initial begin
    forever begin
      @(negedge clk);
      if (hold_asked != hold_done) begin
        hold_done = hold_asked;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        out_ready = 1'b0;
        hold_left--;
      end else begin
        out_ready = ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // checker and predictor, both on the rising edge
  always @(posedge clk) begin
    out_item_t want;
    if (!rst) begin
      if (out_valid && out_ready) begin
        words_out++;
        if (out_data.irq) irq_words++;
        if (timer_words_due.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result word %h with none due", $time, out_data);
        end else begin
          want = timer_words_due.pop_front();
          if (out_data !== want) begin
            mismatches++;
            $display("%0t: expected rd=%h pend=%b irq=%b run=%b, got rd=%h pend=%b irq=%b run=%b",
                     $time, want.read_data, want.update_pending, want.irq, want.running,
                     out_data.read_data, out_data.update_pending, out_data.irq,
                     out_data.running);
          end
        end
      end
      if (in_valid && in_ready) begin
        words_in++;
        want = advance_timer(in_data);
        timer_words_due.push_back(word_typed ? word_resp : want);
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("%0t: no handshake for %0d cycles", $time, QUIET_LIMIT);
        $display("prescaled_reload_down_timer verification failed");
        $finish;
      end
    end
  end

  initial begin
    reset_timer();

    // after reset
    add_row(ACT_READ,  REG_CTRL, 16'h0000, 1'b1, out_item_t'{16'h0000, 1'b0, 1'b0, 1'b0});
    add_row(ACT_READ,  REG_ARR,  16'hffff, 1'b1, out_item_t'{16'hffff, 1'b0, 1'b0, 1'b0});
    add_row(ACT_READ,  REG_CNT,  16'h0000, 1'b1, out_item_t'{16'h0000, 1'b0, 1'b0, 1'b0});
    add_row(ACT_READ,  REG_PSC,  16'hffff, 1'b1, out_item_t'{16'h0000, 1'b0, 1'b0, 1'b0});
    add_row(ACT_READ,  REG_SR,   16'h0000, 1'b1, out_item_t'{16'h0000, 1'b0, 1'b0, 1'b0});
    // tick with the counter disabled
    add_row(ACT_TICK,  REG_NONE, 16'hffff, 1'b1, out_item_t'{16'h0000, 1'b0, 1'b0, 1'b0});
    add_row(ACT_WRITE, REG_PSC,  16'hffff, 1'b0, '0);
    add_row(ACT_READ,  REG_PSC,  16'h0000, 1'b1, out_item_t'{16'hffff, 1'b0, 1'b0, 1'b0});
    add_row(ACT_WRITE, REG_PSC,  16'h0000, 1'b0, '0);
    // reload of zero, wide enable and control writes
    add_row(ACT_WRITE, REG_ARR,  16'h0000, 1'b0, '0);
    add_row(ACT_WRITE, REG_IER,  16'hffff, 1'b0, '0);
    add_row(ACT_WRITE, REG_CTRL, 16'hffff, 1'b0, '0);
    add_row(ACT_READ,  REG_CTRL, 16'h0000, 1'b1, out_item_t'{16'h0019, 1'b0, 1'b0, 1'b1});
    // one-pulse underflow from zero drops the enable
    add_row(ACT_TICK,  REG_CTRL, 16'h0000, 1'b0, '0);
    add_row(ACT_WRITE, REG_SR,   16'hffff, 1'b0, '0);
    add_row(ACT_WRITE, REG_SR,   16'h0000, 1'b0, '0);
    // up counting from the top of the range
    add_row(ACT_WRITE, REG_ARR,  16'hffff, 1'b0, '0);
    add_row(ACT_WRITE, REG_CTRL, 16'h0001, 1'b0, '0);
    add_row(ACT_WRITE, REG_CNT,  16'hffff, 1'b0, '0);
    add_row(ACT_TICK,  REG_CNT,  16'h0000, 1'b0, '0);
    add_row(ACT_READ,  REG_CNT,  16'h0000, 1'b0, '0);
    // update generation with bit0 set, then clear
    add_row(ACT_WRITE, REG_EGR,  16'h0001, 1'b0, '0);
    add_row(ACT_WRITE, REG_EGR,  16'hfffe, 1'b0, '0);
    add_row(ACT_READ,  REG_EGR,  16'hffff, 1'b0, '0);
    add_row(ACT_WRITE, REG_NONE, 16'hffff, 1'b0, '0);
    add_row(ACT_NONE,  REG_NONE, 16'hffff, 1'b0, '0);

    repeat (10) @(negedge clk);
    rst = 1'b0;

    send_idle_pct = 8;
    recv_idle_pct = 55;
    foreach (dir_rows[i]) offer_word(dir_rows[i].word, dir_rows[i].typed, dir_rows[i].resp);
    offer_random(RAND_PER_PHASE);
    wait_drained();

    send_idle_pct = 55;
    recv_idle_pct = 8;
    offer_random(RAND_PER_PHASE);
    wait_drained();

    // no idling; long output hold-off while words keep coming, then a full pause
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_asked++;
    offer_random(30);
    wait_drained();
    offer_random(RAND_PER_PHASE - 30);
    wait_drained();

    repeat (DRAIN_WAIT) @(posedge clk);
    $display("timer run: %0d words in, %0d results checked, %0d counter wraps",
             words_in, words_out, wraps_seen);
    $display("%0d results with irq raised, %0d mismatches", irq_words, mismatches);
    if (mismatches == 0 && timer_words_due.size() == 0) begin
      $display("prescaled_reload_down_timer verification clean");
    end else begin
      $display("prescaled_reload_down_timer verification failed");
    end
    $finish;
  end

endmodule

// ----- prescaled_reload_down_timer.f -----
rtl/core/prdt_pkg.sv
rtl/core/prdt_core.sv
rtl/core/prescaled_reload_down_timer.sv
tb/prescaled_reload_down_timer_tb.sv
